[design/mme_pkg.sv]
`default_nettype none
package mme_pkg;

   // array geometry
   localparam int MAX_DIM = 64;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;

   // field widths
   localparam int SIZE_W  = 7;
   localparam int POS_W   = 6;
   localparam int ELEM_W  = 32;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int OUT_W   = 64;
   localparam int ACC_W   = PROD_W + IDX_W + 2;
   localparam int REQ_W   = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_M  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_N  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_K = 2'd2;

   typedef enum logic [1:0] {
      OP_WR_A = 2'd0,
      OP_WR_B = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic term_valid;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
   } mac_stat_type;

   // clamp a size register to the array dimension
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      eff_size = (size > MAX_SIZE) ? MAX_SIZE : size;
   endfunction

endpackage
`default_nettype wire

[design/matrix_multiply_engine.sv]
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser: op; tdata: row, col, value
//  rsp      out        rsp_tvalid/rsp_tready  tuser: index_error; tdata: c_value
//  csr      in         csr_valid/csr_ready    csr_index, csr_data (always ready)
//
//  A or B element write: taken in idle, next item taken in the following cycle.
//  C read: one term per cycle through the single shared multiply-accumulate unit
//  fed by the two element memories' read ports.
//  An out-of-range C read skips the terms and finishes with index_error set.
//  Reset (synchronous) clears sizes to 64 and the control state; the element
//  memories are not cleared. A stalled result is held in the output register
//  while writes keep going; a read waits at its end until that slot frees.
`default_nettype none
module matrix_multiply_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [5:0] row, [11:6] col, [43:12] value, [47:44] zero
   input  wire logic [mme_pkg::REQ_W-1:0]     req_tdata,
   // [1:0] op
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [63:0] c_value
   output logic      [mme_pkg::OUT_W-1:0]     rsp_tdata,
   // [0] index_error
   output logic                               rsp_tuser,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mme_pkg::SIZE_W-1:0]    csr_data
);
   import mme_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] rows_m_ff, cols_n_ff, inner_k_ff;
   logic [SIZE_W-1:0] m_eff, n_eff, k_eff;

   logic [POS_W-1:0]  in_row, in_col;
   logic [ELEM_W-1:0] in_value;
   logic              accept;
   logic              row_ok_m, col_ok_n, row_ok_k, col_ok_k;

   logic [POS_W-1:0]  row_ff, col_ff;
   logic [SIZE_W-1:0] term_ff, term_in;
   logic              err_ff, err_in;
   logic              issue;
   logic              rd_valid_ff;

   logic              a_we, b_we;
   logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0] a_elem, b_elem;

   mac_ctrl_type      mac_ctrl;
   mac_stat_type      mac_stat;
   logic [OUT_W-1:0]  sum_sat;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff;
   logic              rsp_err_ff;
   logic              rsp_load;

   // size registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= MAX_SIZE;
         cols_n_ff  <= MAX_SIZE;
         inner_k_ff <= MAX_SIZE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_M:  rows_m_ff  <= csr_data;
            CSR_COLS_N:  cols_n_ff  <= csr_data;
            CSR_INNER_K: inner_k_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign m_eff = eff_size(rows_m_ff);
   assign n_eff = eff_size(cols_n_ff);
   assign k_eff = eff_size(inner_k_ff);

   // request decode
   assign in_row   = req_tdata[POS_W-1:0];
   assign in_col   = req_tdata[2*POS_W-1:POS_W];
   assign in_value = req_tdata[2*POS_W+ELEM_W-1:2*POS_W];
   assign accept   = req_tvalid && req_tready;

   assign row_ok_m = SIZE_W'(in_row) < m_eff;
   assign col_ok_n = SIZE_W'(in_col) < n_eff;
   assign row_ok_k = SIZE_W'(in_row) < k_eff;
   assign col_ok_k = SIZE_W'(in_col) < k_eff;

   assign a_we    = accept && (req_tuser == OP_WR_A) && row_ok_m && col_ok_k;
   assign b_we    = accept && (req_tuser == OP_WR_B) && row_ok_k && col_ok_n;
   assign wr_addr = {in_row, in_col};

   // element memories
   assign a_rd_addr = {row_ff, term_ff[IDX_W-1:0]};
   assign b_rd_addr = {term_ff[IDX_W-1:0], col_ff};

   mme_ram #(.WIDTH(ELEM_W), .ADDR_W(ADDR_W)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (in_value),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_elem)
   );

   mme_ram #(.WIDTH(ELEM_W), .ADDR_W(ADDR_W)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (in_value),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_elem)
   );

   // shared multiply-accumulate unit
   mme_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_elem  (a_elem),
      .b_elem  (b_elem),
      .stat    (mac_stat),
      .sum_sat (sum_sat)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in            = state_ff;
      req_tready          = 1'b0;
      issue               = 1'b0;
      term_in             = term_ff;
      err_in              = err_ff;
      rsp_load            = 1'b0;
      mac_ctrl.clear      = 1'b0;
      mac_ctrl.term_valid = rd_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && (req_tuser == OP_READ)) begin
               term_in        = '0;
               mac_ctrl.clear = 1'b1;
               if (row_ok_m && col_ok_n) begin
                  err_in   = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            if (term_ff < k_eff) begin
               issue   = 1'b1;
               term_in = term_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mac_stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   // operand indexes and error flag of the read in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= in_row;
         col_ff <= in_col;
      end
      term_ff <= term_in;
      err_ff  <= err_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= err_ff ? '0 : sum_sat;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire

[design/mme_ram.sv]
`default_nettype none
module mme_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[design/mme_mac.sv]
`default_nettype none
module mme_mac (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mme_pkg::mac_ctrl_type        ctrl,
   input  wire logic [mme_pkg::ELEM_W-1:0]   a_elem,
   input  wire logic [mme_pkg::ELEM_W-1:0]   b_elem,
   output mme_pkg::mac_stat_type             stat,
   output logic      [mme_pkg::OUT_W-1:0]    sum_sat
);
   import mme_pkg::*;

   logic signed [PROD_W-1:0] a_ext;
   logic signed [PROD_W-1:0] b_ext;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic [ACC_W-OUT_W:0]     acc_top;

   // multiply stage, registered; operands sign-extended to the product width
   assign a_ext   = {{(PROD_W-ELEM_W){a_elem[ELEM_W-1]}}, a_elem};
   assign b_ext   = {{(PROD_W-ELEM_W){b_elem[ELEM_W-1]}}, b_elem};
   assign prod_in = a_ext * b_ext;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.term_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // accumulate stage, exact wide sum
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // saturate to the signed output range
   assign acc_top = acc_ff[ACC_W-1:OUT_W-1];

   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         sum_sat = acc_ff[OUT_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum_sat = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   assign stat.busy = prod_valid_ff;

endmodule
`default_nettype wire

[design/mme_checker.sv]
`default_nettype none
module mme_assertions (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [1:0]                req_tuser,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [mme_pkg::OUT_W-1:0] rsp_tdata,
   input  wire logic                      rsp_tuser
);
   import mme_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an index error carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("index error with nonzero value");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a C read keeps the request side busy on the next cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_READ) |=> !req_tready)
      else $error("request taken during a read");

endmodule

bind matrix_multiply_engine mme_assertions u_mme_assertions (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[dv/mme_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and register channels of the matrix engine,
// keeps its own copy of both element stores and the sizes, and checks every
// result beat against the oldest predicted C entry.
module mme_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [mme_pkg::REQ_W-1:0]     req_tdata,
   input  wire logic [1:0]                    req_tuser,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [mme_pkg::OUT_W-1:0]     rsp_tdata,
   input  wire logic                          rsp_tuser,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mme_pkg::SIZE_W-1:0]    csr_data,
   output int                                 fail_count,
   output int                                 due_count
);
   import mme_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] c_value;
      logic             index_error;
   } c_entry_type;

   c_entry_type       c_due [$];
   logic [ELEM_W-1:0] a_elem [DEPTH];
   logic [ELEM_W-1:0] b_elem [DEPTH];
   logic [SIZE_W-1:0] rows_m  = MAX_SIZE;
   logic [SIZE_W-1:0] cols_n  = MAX_SIZE;
   logic [SIZE_W-1:0] inner_k = MAX_SIZE;

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   // size registers above the array dimension act as the full dimension
   function automatic int dim_of(input logic [SIZE_W-1:0] size);
      return (size > MAX_DIM) ? MAX_DIM : int'(size);
   endfunction

   // exact Q32.32 dot product of A row and B column, saturated once at the end
   function automatic logic [OUT_W-1:0] q32_dot(input int row, input int col, input int terms);
      logic signed [71:0] acc;
      logic signed [63:0] a_wide;
      logic signed [63:0] b_wide;
      logic signed [63:0] prod;
      acc = '0;
      for (int t = 0; t < terms; t++) begin
         a_wide = 64'($signed(a_elem[row * MAX_DIM + t]));
         b_wide = 64'($signed(b_elem[t * MAX_DIM + col]));
         prod   = a_wide * b_wide;
         acc    = acc + 72'(prod);
      end
      if (acc[71:63] == '0 || acc[71:63] == '1)
         return acc[63:0];
      return acc[71] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
   endfunction

   always @(posedge clock) begin
      c_entry_type       want;
      logic [1:0]        op;
      logic [ELEM_W-1:0] val;
      int                row, col, m, n, kk;
      if (reset) begin
         rows_m  = MAX_SIZE;
         cols_n  = MAX_SIZE;
         inner_k = MAX_SIZE;
         c_due.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_M:  rows_m  = csr_data;
               CSR_COLS_N:  cols_n  = csr_data;
               CSR_INNER_K: inner_k = csr_data;
               default: ;
            endcase
         end

         // request beat: update stores or predict a C entry
         if (req_tvalid && req_tready) begin
            op  = req_tuser;
            row = int'(req_tdata[POS_W-1:0]);
            col = int'(req_tdata[2*POS_W-1:POS_W]);
            val = req_tdata[2*POS_W +: ELEM_W];
            m   = dim_of(rows_m);
            n   = dim_of(cols_n);
            kk  = dim_of(inner_k);
            case (op)
               OP_WR_A: begin
                  if (row < m && col < kk) a_elem[row * MAX_DIM + col] = val;
               end
               OP_WR_B: begin
                  if (row < kk && col < n) b_elem[row * MAX_DIM + col] = val;
               end
               OP_READ: begin
                  if (row < m && col < n)
                     c_due.push_back('{c_value: q32_dot(row, col, kk), index_error: 1'b0});
                  else
                     c_due.push_back('{c_value: '0, index_error: 1'b1});
               end
               default: ;
            endcase
         end

         // result beat
         if (rsp_tvalid && rsp_tready) begin
            if (c_due.size() == 0) begin
               $error("unexpected result beat: c_value %h index_error %b", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = c_due.pop_front();
               if (rsp_tdata !== want.c_value) begin
                  $error("c_value mismatch: expected %h, got %h", want.c_value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.index_error) begin
                  $error("index_error mismatch: expected %b, got %b",
                         want.index_error, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
      due_count = c_due.size();
   end

endmodule

[dv/tb_matrix_multiply_engine.sv]
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
   import mme_pkg::*;

   localparam logic [1:0]           OP_NONE        = 2'd3;   // no meaning, dropped by the block
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;   // unused register index
   localparam int                   PHASES         = 10;
   localparam int                   ITEMS_PER_PHASE = 175;
   localparam int                   LATENCY        = MAX_DIM + 16;
   localparam int                   CYCLE_LIMIT    = 1_000_000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic [1:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [OUT_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SIZE_W-1:0]    csr_data   = '0;

   int                   fail_count;
   int                   due_count;
   int unsigned          cycles = 0;

   // stimulus bookkeeping
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   eff_m = MAX_DIM;
   int                   eff_n = MAX_DIM;
   int                   eff_k = MAX_DIM;
   int                   beats = 0;
   int                   reads = 0;
   bit                   a_set [DEPTH];
   bit                   b_set [DEPTH];

   // size settings of the random phases; the last two are drawn at run time
   int ph_m [PHASES] = '{4, 1, 8, 0, 5, 127, 64, 3, 0, 0};
   int ph_n [PHASES] = '{4, 1, 3, 5, 6, 127, 64, 64, 0, 0};
   int ph_k [PHASES] = '{4, 1, 16, 3, 0, 127, 64, 2, 0, 0};

   always #1 clock = ~clock;

   matrix_multiply_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mme_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .due_count  (due_count)
   );

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL matrix_multiply_engine");
         $finish;
      end
   end

   // element values: extremes, small Q16.16 numbers and raw random bits
   function automatic logic [ELEM_W-1:0] elem_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: return $urandom();
      endcase
   endfunction

   // index below limit, leaning toward the first few rows/columns so reads reuse data
   function automatic int pick(input int limit);
      if (limit > 4 && $urandom_range(0, 3) != 0)
         return $urandom_range(0, 3);
      return $urandom_range(0, limit - 1);
   endfunction

   // one request beat, with optional idle cycles ahead of it
   task automatic push_req(input logic [1:0] op, input int row, input int col,
                           input logic [ELEM_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, val, POS_W'(col), POS_W'(row)};
      do @(posedge clock); while (!req_tready);
      // remember which store entries hold data
      if (op == OP_WR_A && row < eff_m && col < eff_k) a_set[row * MAX_DIM + col] = 1'b1;
      if (op == OP_WR_B && row < eff_k && col < eff_n) b_set[row * MAX_DIM + col] = 1'b1;
      if (op != OP_NONE) beats++;
      if (op == OP_READ) reads++;
   endtask

   // C read; loads any A/B entry it would touch that was never written
   task automatic read_c(input int row, input int col);
      if (row < eff_m && col < eff_n) begin
         for (int t = 0; t < eff_k; t++) begin
            if (!a_set[row * MAX_DIM + t]) push_req(OP_WR_A, row, t, elem_value());
            if (!b_set[t * MAX_DIM + col]) push_req(OP_WR_B, t, col, elem_value());
         end
      end
      push_req(OP_READ, row, col, $urandom());
   endtask

   // hold the sender until every predicted result is back and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (due_count != 0) @(negedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= SIZE_W'(data);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_sizes(input int m, input int n, input int k);
      write_reg(CSR_ROWS_M, m);
      write_reg(CSR_COLS_N, n);
      write_reg(CSR_INNER_K, k);
      csr_valid <= 1'b0;
      eff_m = (m > MAX_DIM) ? MAX_DIM : m;
      eff_n = (n > MAX_DIM) ? MAX_DIM : n;
      eff_k = (k > MAX_DIM) ? MAX_DIM : k;
   endtask

   task automatic random_item();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30 && eff_m > 0 && eff_k > 0)
         push_req(OP_WR_A, pick(eff_m), pick(eff_k), elem_value());
      else if (roll < 60 && eff_k > 0 && eff_n > 0)
         push_req(OP_WR_B, pick(eff_k), pick(eff_n), elem_value());
      else if (roll < 88 && eff_m > 0 && eff_n > 0)
         read_c(pick(eff_m), pick(eff_n));
      else if (roll < 94)
         read_c($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
      else if (roll < 98)
         push_req(2'($urandom_range(0, 1)), $urandom_range(0, MAX_DIM - 1),
                  $urandom_range(0, MAX_DIM - 1), elem_value());
      else
         push_req(OP_NONE, $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                  $urandom());
   endtask

   initial begin
      int  start;
      bit  paused;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 2x3 by 3x2, both saturation directions, range errors, dead opcode
      set_sizes(2, 2, 3);
      for (int t = 0; t < 3; t++) push_req(OP_WR_A, 0, t, 32'h8000_0000);
      for (int t = 0; t < 3; t++) push_req(OP_WR_B, t, 0, 32'h8000_0000);
      for (int t = 0; t < 3; t++) push_req(OP_WR_B, t, 1, 32'h7FFF_FFFF);
      read_c(0, 0);
      read_c(0, 1);
      push_req(OP_WR_A, 1, 0, 32'h0001_0000);
      push_req(OP_WR_A, 1, 1, 32'hFFFF_0000);
      push_req(OP_WR_A, 1, 2, 32'h0000_0001);
      read_c(1, 0);
      read_c(1, 1);
      read_c(2, 0);
      read_c(0, 2);
      read_c(MAX_DIM - 1, MAX_DIM - 1);
      push_req(OP_WR_A, 0, 3, 32'h1234_5678);
      push_req(OP_WR_B, 3, 0, 32'h1234_5678);
      push_req(OP_WR_A, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);
      push_req(OP_NONE, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);

      // random phases, each with its own sizes and idle/backpressure mix
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (ph_m[p] == 0 && ph_n[p] == 0) begin
            ph_m[p] = $urandom_range(1, 12);
            ph_n[p] = $urandom_range(1, 12);
            ph_k[p] = $urandom_range(1, 12);
         end
         if (p == 0) write_reg(CSR_SPARE, 42);
         set_sizes(ph_m[p], ph_n[p], ph_k[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         start  = beats;
         paused = 1'b0;
         while (beats - start < ITEMS_PER_PHASE) begin
            // mid-phase pause until all results have drained
            if (!paused && beats - start >= ITEMS_PER_PHASE / 2) begin
               settle();
               paused = 1'b1;
            end
            random_item();
         end
      end

      settle();
      @(negedge clock);
      $display("Run covered %0d request beats (%0d C reads) over %0d size settings,",
               beats, reads, PHASES + 1);
      $display("with free-running, sender-idle, result-stall and mixed traffic.");
      if (fail_count == 0)
         $display("PASS matrix_multiply_engine");
      else
         $display("FAIL matrix_multiply_engine");
      $finish;
   end

endmodule
